[rtl/fms_pkg.sv]
// Shared types and constants of the frame RMS cosine matcher.
`default_nettype none
package fms_pkg;

  localparam int DEF_FRAME_COUNT  = 50;
  localparam int DEF_FRAME_LENGTH = 320;
  localparam int QUEUE_DEPTH      = 4;

  localparam int SUM_MAX_W  = 43;
  localparam int FILL_MAX_W = 13;
  localparam int IDX_MAX_W  = 9;
  localparam int RMS_W      = 24;
  localparam int ROOT_IN_W  = 64;
  localparam int ROOT_OUT_W = 32;
  localparam int ROOT_STEPS = 32;
  localparam int SIM_W      = 16;

  localparam logic [15:0] THRESH_RESET = 16'd22938;
  localparam logic [15:0] SIM_ONE      = 16'h8000;

  localparam logic [1:0] KIND_ENROLL = 2'd0;
  localparam logic [1:0] KIND_VERIFY = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  localparam logic [1:0] STATUS_ENROLLED = 2'd0;
  localparam logic [1:0] STATUS_MATCH    = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;
  localparam logic [1:0] STATUS_NO_REF   = 2'd3;

  localparam logic MODE_ENROLL = 1'b0;

  typedef struct packed {
    logic                  del;
    logic                  frame;
    logic                  fin;
    logic                  mode;
    logic [SUM_MAX_W-1:0]  sum;
    logic [FILL_MAX_W-1:0] fill;
    logic [IDX_MAX_W-1:0]  idx;
  } cmd_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_DIV,
    BS_RMS_ROOT,
    BS_FRAME,
    BS_END,
    BS_NORM_ROOT,
    BS_LIVE_ROOT,
    BS_MUL,
    BS_SAT,
    BS_COS,
    BS_EMIT
  } back_state_t;

endpackage
`default_nettype wire

[rtl/fms_front.sv]
// Front end: takes sample words, sums squares per frame, issues frame, end and delete commands.
`default_nettype none
module fms_front #(
  parameter int FRAME_COUNT  = fms_pkg::DEF_FRAME_COUNT,
  parameter int FRAME_LENGTH = fms_pkg::DEF_FRAME_LENGTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   kind,
  input  wire logic [15:0]  sample,
  input  wire logic         last,
  input  wire logic         q_full,
  output logic              push,
  output fms_pkg::cmd_t     push_data
);
  import fms_pkg::*;

  localparam int FILL_W = $clog2(FRAME_LENGTH + 1);
  localparam int SQ_W   = 30 + FILL_W;
  localparam int CNT_W  = $clog2(FRAME_COUNT + 1);

  logic              in_rec;
  logic              mode;
  logic [SQ_W-1:0]   sum;
  logic [FILL_W-1:0] fill;
  logic [CNT_W-1:0]  idx;

  logic              is_smp, accept, take, frame_done, mode_cur;
  logic [SQ_W-1:0]   sum_cur, sum_new;
  logic [FILL_W-1:0] fill_cur, fill_new;
  logic [CNT_W-1:0]  idx_cur;
  logic [31:0]       sq;

  always_comb begin
    is_smp   = (kind == KIND_ENROLL) || (kind == KIND_VERIFY);
    accept   = in_valid && !q_full;
    mode_cur = in_rec ? mode : kind[0];
    sum_cur  = in_rec ? sum : '0;
    fill_cur = in_rec ? fill : '0;
    idx_cur  = in_rec ? idx : '0;
    take     = idx_cur < CNT_W'(FRAME_COUNT);
    sq       = 32'($signed(sample) * $signed(sample));
    sum_new  = take ? sum_cur + SQ_W'(sq[30:0]) : sum_cur;
    fill_new = take ? fill_cur + 1'b1 : fill_cur;
    frame_done = take && ((fill_new == FILL_W'(FRAME_LENGTH)) || last);
    push = accept && ((kind == KIND_DELETE) || (is_smp && (frame_done || last)));
    push_data.del   = (kind == KIND_DELETE);
    push_data.frame = frame_done;
    push_data.fin   = last;
    push_data.mode  = mode_cur;
    push_data.sum   = SUM_MAX_W'(sum_new);
    push_data.fill  = FILL_MAX_W'(fill_new);
    push_data.idx   = IDX_MAX_W'(idx_cur);
    in_stall = q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_rec <= 1'b0;
      mode   <= MODE_ENROLL;
      sum    <= '0;
      fill   <= '0;
      idx    <= '0;
    end else if (accept && is_smp) begin
      if (last) begin
        in_rec <= 1'b0;
        mode   <= MODE_ENROLL;
        sum    <= '0;
        fill   <= '0;
        idx    <= '0;
      end else begin
        in_rec <= 1'b1;
        mode   <= mode_cur;
        if (frame_done) begin
          sum  <= '0;
          fill <= '0;
          idx  <= idx_cur + 1'b1;
        end else begin
          sum  <= sum_new;
          fill <= fill_new;
          idx  <= idx_cur;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/fms_queue.sv]
// Short command queue between front and back.
`default_nettype none
module fms_queue #(
  parameter int DEPTH = fms_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fms_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output fms_pkg::cmd_t      pop_data,
  output logic               empty
);
  import fms_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  always_comb begin
    full     = count == CNT_W'(DEPTH);
    empty    = count == '0;
    pop_data = slots[rptr];
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(push && !full) - CNT_W'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

[rtl/fms_root.sv]
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module fms_root (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [fms_pkg::ROOT_IN_W-1:0]  value,
  output logic                                busy,
  output logic                                done,
  output logic [fms_pkg::ROOT_OUT_W-1:0]      root
);
  import fms_pkg::*;

  localparam int STEP_W = $clog2(ROOT_STEPS);

  logic [ROOT_IN_W-1:0] v, res, bit_r, trial;
  logic [STEP_W-1:0]    cnt;
  logic                 ge;

  always_comb begin
    trial = res + bit_r;
    ge    = v >= trial;
    root  = res[ROOT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == STEP_W'(ROOT_STEPS - 1));
      if (start) begin
        v     <= value;
        res   <= '0;
        bit_r <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          v   <= v - trial;
          res <= (res >> 1) + bit_r;
        end else begin
          res <= res >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt   <= cnt + 1'b1;
        if (cnt == STEP_W'(ROOT_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/fms_back.sv]
// Back end: frame RMS, reference store, norms and cosine similarity sequencer.
`default_nettype none
module fms_back #(
  parameter int FRAME_COUNT  = fms_pkg::DEF_FRAME_COUNT,
  parameter int FRAME_LENGTH = fms_pkg::DEF_FRAME_LENGTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire fms_pkg::cmd_t q_data,
  output logic               pop,
  input  wire logic          cfg_write,
  input  wire logic [15:0]   cfg_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         status,
  output logic [15:0]        similarity,
  output logic               ref_present
);
  import fms_pkg::*;

  localparam int FILL_W = $clog2(FRAME_LENGTH + 1);
  localparam int SQ_W   = 30 + FILL_W;
  localparam int DVD_W  = SQ_W + 16;
  localparam int CNT_W  = $clog2(FRAME_COUNT + 1);
  localparam int IDX_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int STEP_W = $clog2(DVD_W);
  localparam int R_W    = 65;

  back_state_t state, state_next;

  cmd_t                  cmd;
  logic [15:0]           thr;
  logic                  ref_valid;
  logic [CNT_W-1:0]      ref_len, pend_len;
  logic [ROOT_OUT_W-1:0] ref_root, live_root;
  logic [63:0]           pend_na, dot, live, den;
  logic [DVD_W-1:0]      dvd;
  logic [FILL_W-1:0]     rem;
  logic [STEP_W-1:0]     cnt;
  logic [RMS_W-1:0]      rms, rd;
  logic [R_W-1:0]        r;
  logic [16:0]           q;
  logic [SIM_W-1:0]      res_sim;
  logic                  root_pend;
  logic [RMS_W-1:0]      mem [FRAME_COUNT];

  logic                  root_start, root_busy, root_done, emit_go, first;
  logic [ROOT_IN_W-1:0]  root_value;
  logic [ROOT_OUT_W-1:0] root;
  logic [FILL_W:0]       rem_sh;
  logic                  dge, cge;
  logic [R_W-1:0]        r_t;
  logic [16:0]           q_next;
  logic [RMS_W-1:0]      refv;
  logic [1:0]            emit_status;
  logic [SIM_W-1:0]      emit_sim;

  fms_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (root_value),
    .busy  (root_busy),
    .done  (root_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    root_start = 1'b0;
    root_value = '0;
    emit_go    = !out_valid || !out_stall;
    case (state)
      BS_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_data.del) begin
            state_next = BS_IDLE;
          end else if (q_data.frame) begin
            state_next = BS_DIV;
          end else begin
            state_next = BS_END;
          end
        end
      end
      BS_DIV: begin
        if (cnt == STEP_W'(DVD_W - 1)) begin
          state_next = BS_RMS_ROOT;
        end
      end
      BS_RMS_ROOT: begin
        root_start = !root_pend;
        root_value = ROOT_IN_W'(dvd);
        if (root_done) begin
          state_next = BS_FRAME;
        end
      end
      BS_FRAME: begin
        state_next = cmd.fin ? BS_END : BS_IDLE;
      end
      BS_END: begin
        if (cmd.mode == MODE_ENROLL) begin
          state_next = BS_NORM_ROOT;
        end else if (!ref_valid || live == '0 || ref_root == '0) begin
          state_next = BS_EMIT;
        end else begin
          state_next = BS_LIVE_ROOT;
        end
      end
      BS_NORM_ROOT: begin
        root_start = !root_pend;
        root_value = pend_na;
        if (root_done) begin
          state_next = BS_EMIT;
        end
      end
      BS_LIVE_ROOT: begin
        root_start = !root_pend;
        root_value = live;
        if (root_done) begin
          state_next = BS_MUL;
        end
      end
      BS_MUL: state_next = BS_SAT;
      BS_SAT: begin
        state_next = ({1'b0, dot} >= {den, 1'b0}) ? BS_EMIT : BS_COS;
      end
      BS_COS: begin
        if (cnt == STEP_W'(15)) begin
          state_next = BS_EMIT;
        end
      end
      BS_EMIT: begin
        if (emit_go) begin
          state_next = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    rem_sh = {rem, dvd[DVD_W-1]};
    dge    = rem_sh >= {1'b0, cmd.fill[FILL_W-1:0]};
    r_t    = (cnt == '0) ? r : {r[R_W-2:0], 1'b0};
    cge    = r_t >= {1'b0, den};
    q_next = {q[15:0], cge};
    first  = cmd.idx == '0;
    refv   = (cmd.idx[CNT_W-1:0] < ref_len) ? rd : '0;
    if (cmd.mode == MODE_ENROLL) begin
      emit_status = STATUS_ENROLLED;
      emit_sim    = '0;
    end else if (!ref_valid) begin
      emit_status = STATUS_NO_REF;
      emit_sim    = '0;
    end else begin
      emit_status = (res_sim >= thr) ? STATUS_MATCH : STATUS_MISMATCH;
      emit_sim    = res_sim;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BS_FRAME && cmd.mode == MODE_ENROLL) begin
      mem[cmd.idx[IDX_W-1:0]] <= rms;
    end
    if (pop && q_data.frame) begin
      rd <= mem[q_data.idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= THRESH_RESET;
      ref_valid <= 1'b0;
      root_pend <= 1'b0;
      out_valid <= 1'b0;
      ref_len   <= '0;
    end else begin
      if (cfg_write) begin
        thr <= cfg_data;
      end
      if (root_start) begin
        root_pend <= 1'b1;
      end else if (root_done) begin
        root_pend <= 1'b0;
      end
      if (out_valid && !out_stall && state != BS_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        BS_IDLE: begin
          if (!q_empty) begin
            cmd <= q_data;
            if (q_data.del) begin
              ref_valid <= 1'b0;
            end
            dvd <= {q_data.sum[SQ_W-1:0], 16'b0};
            rem <= '0;
            cnt <= '0;
          end
        end
        BS_DIV: begin
          rem <= dge ? FILL_W'(rem_sh - {1'b0, cmd.fill[FILL_W-1:0]}) : FILL_W'(rem_sh);
          dvd <= {dvd[DVD_W-2:0], dge};
          cnt <= cnt + 1'b1;
        end
        BS_RMS_ROOT: begin
          if (root_done) begin
            rms <= root[RMS_W-1:0];
          end
        end
        BS_FRAME: begin
          if (cmd.mode == MODE_ENROLL) begin
            pend_na  <= (first ? 64'd0 : pend_na) + 64'(rms * rms);
            pend_len <= CNT_W'(cmd.idx[CNT_W-1:0] + 1'b1);
          end else begin
            dot  <= (first ? 64'd0 : dot) + 64'(refv * rms);
            live <= (first ? 64'd0 : live) + 64'(rms * rms);
          end
        end
        BS_END: begin
          res_sim <= '0;
        end
        BS_NORM_ROOT: begin
          if (root_done) begin
            ref_root  <= root;
            ref_len   <= pend_len;
            ref_valid <= 1'b1;
          end
        end
        BS_LIVE_ROOT: begin
          if (root_done) begin
            live_root <= root;
          end
        end
        BS_MUL: begin
          den <= 64'(ref_root * live_root);
        end
        BS_SAT: begin
          res_sim <= SIM_ONE;
          r       <= R_W'(dot);
          q       <= '0;
          cnt     <= '0;
        end
        BS_COS: begin
          r   <= cge ? r_t - {1'b0, den} : r_t;
          q   <= q_next;
          cnt <= cnt + 1'b1;
          if (cnt == STEP_W'(15)) begin
            res_sim <= (q_next > 17'd32768) ? SIM_ONE : q_next[SIM_W-1:0];
          end
        end
        BS_EMIT: begin
          if (emit_go) begin
            out_valid   <= 1'b1;
            status      <= emit_status;
            similarity  <= emit_sim;
            ref_present <= (cmd.mode == MODE_ENROLL) ? 1'b1 : ref_valid;
          end
        end
        default: ;
      endcase
    end
  end

  a_cos_den: assert property (@(posedge clk) disable iff (rst)
    (state == BS_COS) |-> (den != '0))
    else $error("cosine division with zero divisor");

  a_root_start: assert property (@(posedge clk) disable iff (rst)
    root_start |-> !root_busy)
    else $error("root unit started while busy");

  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (similarity <= SIM_ONE))
    else $error("similarity above one");

  a_no_ref: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_NO_REF) |-> (similarity == '0 && !ref_present))
    else $error("no-reference word carries data");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (pop && !q_data.del) |=> (state == BS_DIV || state == BS_END))
    else $error("command popped without dispatch");

endmodule
`default_nettype wire

[rtl/frame_rms_cosine_matcher_unit.sv]
// Top level of the frame RMS cosine matcher.
//
//   port group    dir  handshake            payload
//   input word    in   in_valid / in_stall   kind, sample, last
//   result word   out  out_valid / out_stall status, similarity, ref_present
//   config        in   cfg_write            cfg_data (similarity threshold)
//
// The front takes one input word per cycle while the command queue has room.
// Each closed frame takes the back end through a pop, at FRAME_LENGTH 320 a
// 55-step serial divide (46 + bits of FRAME_LENGTH), a root, and accumulate.
// A recording end adds a root and the emit for enroll, and for verify at most a root,
// multiply, 16-step divide and emit. The queue holds four commands.
// Reset (rst, synchronous) clears the reference and sets the threshold to 22938.
// in_stall is high while the queue is full; a stalled result holds its word.
`default_nettype none
module frame_rms_cosine_matcher_unit #(
  parameter int FRAME_COUNT  = fms_pkg::DEF_FRAME_COUNT,
  parameter int FRAME_LENGTH = fms_pkg::DEF_FRAME_LENGTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] sample,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [15:0]      similarity,
  output logic             ref_present,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data
);
  import fms_pkg::*;

  cmd_t push_data, pop_data;
  logic push, pop, q_full, q_empty;

  fms_front #(
    .FRAME_COUNT  (FRAME_COUNT),
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .sample    (sample),
    .last      (last),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  fms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  fms_back #(
    .FRAME_COUNT  (FRAME_COUNT),
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .similarity  (similarity),
    .ref_present (ref_present)
  );

endmodule
`default_nettype wire

[sim/frame_rms_cosine_matcher_unit_tb.sv]
// Testbench of the frame RMS cosine matcher: random recordings checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module frame_rms_cosine_matcher_unit_tb;
  import fms_pkg::*;

  localparam int FCOUNT = 50;
  localparam int FLEN   = 320;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = KIND_ENROLL;
  logic [15:0] sample = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [15:0] similarity;
  logic ref_present;
  logic cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] similarity;
    logic        ref_present;
  } verdict_t;

  verdict_t verdict_q[$];

  // predictor state
  logic [23:0] p_ref [FCOUNT];
  logic        p_ref_valid;
  logic        p_mode;
  logic        p_active;
  logic [63:0] p_sqsum;
  int          p_fill;
  int          p_frame;
  logic [63:0] p_dot;
  logic [63:0] p_live;
  logic [15:0] p_thresh;

  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit done = 1'b0;

  frame_rms_cosine_matcher_unit DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .sample(sample), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .similarity(similarity), .ref_present(ref_present),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic close_frame();
    logic [63:0] rms;
    if (p_fill == 0 || p_frame >= FCOUNT) return;
    rms = int_root((p_sqsum << 16) / 64'(p_fill)) & 64'hFFFFFF;
    if (p_mode == MODE_ENROLL) begin
      p_ref[p_frame] = rms[23:0];
    end else begin
      if (p_ref_valid) p_dot += 64'(p_ref[p_frame]) * rms;
      p_live += rms * rms;
    end
    p_frame++;
    p_sqsum = 0;
    p_fill = 0;
  endtask

  function automatic logic [15:0] cosine_q15();
    logic [63:0] na, den, q, r;
    na = 0;
    for (int i = 0; i < FCOUNT; i++) na += 64'(p_ref[i]) * 64'(p_ref[i]);
    if (na == 0 || p_live == 0) return 16'd0;
    den = int_root(na) * int_root(p_live);
    if (den == 0) return 16'd0;
    q = p_dot / den;
    if (q >= 2) return SIM_ONE;
    r = p_dot % den;
    for (int i = 0; i < 15; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return (q > 32768) ? SIM_ONE : q[15:0];
  endfunction

  task automatic predict_word(logic [1:0] k, logic [15:0] s, logic l);
    verdict_t v;
    logic [15:0] sim;
    logic signed [31:0] sv;
    if (k == KIND_DELETE) begin
      p_ref_valid = 1'b0;
      return;
    end
    if (k == KIND_SPARE) return;
    if (!p_active) begin
      p_active = 1'b1;
      p_mode = k[0];
      p_sqsum = 0; p_fill = 0; p_frame = 0; p_dot = 0; p_live = 0;
    end
    if (p_frame < FCOUNT) begin
      sv = $signed(s);
      p_sqsum += 64'(sv * sv);
      p_fill++;
      if (p_fill >= FLEN) close_frame();
    end
    if (!l) return;
    close_frame();
    if (p_mode == MODE_ENROLL) begin
      for (int i = p_frame; i < FCOUNT; i++) p_ref[i] = '0;
      p_ref_valid = 1'b1;
      v = '{STATUS_ENROLLED, 16'd0, 1'b1};
    end else if (!p_ref_valid) begin
      v = '{STATUS_NO_REF, 16'd0, 1'b0};
    end else begin
      sim = cosine_q15();
      v = '{(sim >= p_thresh) ? STATUS_MATCH : STATUS_MISMATCH, sim, 1'b1};
    end
    verdict_q.push_back(v);
    p_active = 1'b0;
    p_mode = MODE_ENROLL;
    p_sqsum = 0; p_fill = 0; p_frame = 0; p_dot = 0; p_live = 0;
  endtask

  // valid stays high across back-to-back words; a gap drops it
  task automatic send_word(logic [1:0] k, logic [15:0] s, logic l);
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    sample <= s;
    last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(k, s, l);
  endtask

  // sample value: extremes, small or full range
  function automatic logic [15:0] pick_sample(int style);
    case (style)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_recording(logic [1:0] k, int n, int style);
    for (int i = 0; i < n; i++) begin
      send_word((i == 0) ? k : 2'($urandom_range(0, 1)),
                (style < 0) ? pick_sample($urandom_range(0, 3)) : pick_sample(style),
                i == n - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] t);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= t;
    @(posedge clk);
    cfg_write <= 1'b0;
    p_thresh = t;
  endtask

  task automatic test_directed();
    send_word(KIND_VERIFY, 16'h1234, 1'b1);
    send_recording(KIND_ENROLL, 5, 1);
    send_recording(KIND_VERIFY, 5, 0);
    send_recording(KIND_VERIFY, 3, 2);
    send_word(KIND_SPARE, 16'hFFFF, 1'b1);
    send_word(KIND_DELETE, 16'hFFFF, 1'b1);
    send_recording(KIND_VERIFY, 2, 3);
    send_recording(KIND_ENROLL, 2, 2);
    send_word(KIND_VERIFY, 16'h0001, 1'b0);
    send_word(KIND_DELETE, 16'h0000, 1'b0);
    send_word(KIND_ENROLL, 16'h4000, 1'b1);
  endtask

  task automatic test_long_recordings();
    send_recording(KIND_ENROLL, 330, -1);
    send_recording(KIND_VERIFY, 160, -1);
    write_threshold(16'd0);
    send_recording(KIND_VERIFY, 20, -1);
  endtask

  task automatic test_random(int count);
    int sent;
    int n;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0: begin send_word(KIND_DELETE, 16'($urandom), 1'($urandom)); n = 1; end
        1: begin send_word(KIND_SPARE, 16'($urandom), 1'($urandom)); n = 1; end
        2, 3: begin n = $urandom_range(1, 12); send_recording(KIND_ENROLL, n, -1); end
        default: begin
          n = $urandom_range(1, 12);
          send_recording(KIND_VERIFY, n, $urandom_range(0, 4) == 0 ? 2 : -1);
        end
      endcase
      sent += n;
    end
  endtask

  task automatic test_pressure();
    hold_off = 1'b1;
    send_recording(KIND_ENROLL, 3, -1);
    send_recording(KIND_VERIFY, 3, -1);
    for (int i = 0; i < 6; i++) send_recording(KIND_VERIFY, 1, -1);
  endtask

  initial begin
    for (int i = 0; i < FCOUNT; i++) p_ref[i] = '0;
    p_ref_valid = 0; p_mode = 0; p_active = 0; p_sqsum = 0; p_fill = 0;
    p_frame = 0; p_dot = 0; p_live = 0; p_thresh = THRESH_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_long_recordings();
    write_threshold(16'd32768);
    test_random(50);
    write_threshold(16'hFFFF);
    test_random(25);
    write_threshold(16'($urandom_range(20000, 32768)));
    test_pressure();
    test_random(30);
    drain();
    done = 1'b1;
    if (errors == 0) begin
      $display("frame_rms_cosine_matcher_unit test passed");
    end else begin
      $display("frame_rms_cosine_matcher_unit test failed");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else begin
        phase++;
        if ((phase / 64) % 2 == 0) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, similarity, ref_present};
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %p", got);
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("frame_rms_cosine_matcher_unit test failed");
      $finish;
    end
  end

endmodule
`default_nettype wire
